// File: src/utf8_code_point_decoder_unit_assert.svh
// assertion macros used by the decoder unit
`ifndef UTF8_CODE_POINT_DECODER_UNIT_ASSERT_SVH
`define UTF8_CODE_POINT_DECODER_UNIT_ASSERT_SVH

// antecedent holds, consequent must hold in the same cycle
`define UTF8D_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("utf8 decoder: same-cycle check failed");

// antecedent holds, consequent must hold in the next cycle
`define UTF8D_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("utf8 decoder: next-cycle check failed");

`endif

// File: src/utf8d_pkg.sv
package utf8d_pkg;

  localparam logic [20:0] CpReplacement = 21'h00FFFD;
  localparam logic [20:0] CpMax         = 21'h10FFFF;
  localparam logic [2:0]  AvailMax      = 3'd4;

  localparam logic [7:0] ContLo       = 8'h80;
  localparam logic [7:0] ContHi       = 8'hBF;
  localparam logic [7:0] LoAfterE0    = 8'hA0;
  localparam logic [7:0] HiAfterEd    = 8'h9F;
  localparam logic [7:0] LoAfterF0    = 8'h90;
  localparam logic [7:0] HiAfterF4    = 8'h8F;
  localparam logic [7:0] AsciiEnd     = 8'h80;
  localparam logic [7:0] LeadTwoMin   = 8'hC2;
  localparam logic [7:0] LeadThreeMin = 8'hE0;
  localparam logic [7:0] LeadFourMin  = 8'hF0;
  localparam logic [7:0] LeadFourEnd  = 8'hF5;
  localparam logic [7:0] LeadE0       = 8'hE0;
  localparam logic [7:0] LeadEd       = 8'hED;
  localparam logic [7:0] LeadF0       = 8'hF0;
  localparam logic [7:0] LeadF4       = 8'hF4;

  localparam int unsigned NumLanes = 3;

  typedef enum logic [2:0] {
    SEQ_INVALID = 3'd0,
    SEQ_ONE     = 3'd1,
    SEQ_TWO     = 3'd2,
    SEQ_THREE   = 3'd3,
    SEQ_FOUR    = 3'd4
  } seq_len_e;

  typedef struct packed {
    seq_len_e   len;
    logic [7:0] lo;
    logic [7:0] hi;
  } lead_info_t;

  typedef struct packed {
    logic [20:0] code_point;
    logic [2:0]  bytes_consumed;
  } result_t;

endpackage

// File: src/utf8d_if.sv
interface utf8d_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_first;
  logic [7:0] byte_second;
  logic [7:0] byte_third;
  logic [7:0] byte_fourth;
  logic [2:0] bytes_available;

  modport source (output valid, byte_first, byte_second, byte_third, byte_fourth,
                  bytes_available, input ready);
  modport sink (input valid, byte_first, byte_second, byte_third, byte_fourth,
                bytes_available, output ready);
endinterface

interface utf8d_out_if;
  logic        valid;
  logic        ready;
  logic [20:0] code_point;
  logic [2:0]  bytes_consumed;

  modport source (output valid, code_point, bytes_consumed, input ready);
  modport sink (input valid, code_point, bytes_consumed, output ready);
endinterface

// File: src/utf8_code_point_decoder_unit.sv
// strict utf-8 decoder for one sequence at the head of a four-byte window
// in_item: byte_first..byte_fourth and bytes_available (counts above four act
//   as four); a transfer happens when valid and ready are both high
// out_item: code_point and bytes_consumed for the first sequence; U+FFFD with
//   size 0 for an empty window, size 1 for any invalid or truncated sequence
// the lead byte class and three continuation lanes are checked side by side
// in combinational logic and merged into one result, which is then registered
// the merged result goes into the main register, or into the skid entry
//   while the main register is full and the receiver holds ready low
// throughput: one window per cycle; in_item.ready only drops while the skid
//   entry is occupied
// a two-entry output buffer (main register and skid) keeps in_item.ready
// registered: input stalls only when both entries hold results, i.e. after
// the receiver has held ready low while the main register is
// full and a further transfer arrives
// reset clears both entries; no results are pending afterwards
`include "utf8_code_point_decoder_unit_assert.svh"

module utf8_code_point_decoder_unit (
  input  logic        clk,
  input  logic        rst,
  utf8d_in_if.sink    in_item,
  utf8d_out_if.source out_item
);

  utf8d_pkg::lead_info_t                  info;
  logic [utf8d_pkg::NumLanes-1:0]         cont_ok;
  logic [utf8d_pkg::NumLanes*6-1:0]       cont_bits;
  logic [utf8d_pkg::NumLanes-1:0][7:0]    lane_data;
  logic [utf8d_pkg::NumLanes-1:0][7:0]    lane_lo;
  logic [utf8d_pkg::NumLanes-1:0][7:0]    lane_hi;
  utf8d_pkg::result_t                     res_new;
  utf8d_pkg::result_t                     out_res;
  utf8d_pkg::result_t                     skid_res;
  logic                                   out_valid;
  logic                                   skid_valid;
  logic                                   in_fire;
  logic                                   out_fire;

  utf8d_lead u_lead (
    .lead (in_item.byte_first),
    .info (info)
  );

  assign lane_data = {in_item.byte_fourth, in_item.byte_third, in_item.byte_second};
  // only the second byte gets the tightened range
  assign lane_lo   = {utf8d_pkg::ContLo, utf8d_pkg::ContLo, info.lo};
  assign lane_hi   = {utf8d_pkg::ContHi, utf8d_pkg::ContHi, info.hi};

  for (genvar g = 0; g < utf8d_pkg::NumLanes; g++) begin : g_lane
    utf8d_lane u_lane (
      .data (lane_data[g]),
      .lo   (lane_lo[g]),
      .hi   (lane_hi[g]),
      .ok   (cont_ok[g]),
      .bits (cont_bits[g*6 +: 6])
    );
  end

  utf8d_merge u_merge (
    .info      (info),
    .lead      (in_item.byte_first),
    .cont_ok   (cont_ok),
    .cont_bits (cont_bits),
    .avail     (in_item.bytes_available),
    .res       (res_new)
  );

  assign in_item.ready           = !skid_valid;
  assign in_fire                 = in_item.valid && in_item.ready;
  assign out_fire                = out_valid && out_item.ready;
  assign out_item.valid          = out_valid;
  assign out_item.code_point     = out_res.code_point;
  assign out_item.bytes_consumed = out_res.bytes_consumed;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_fire || !out_valid) begin
      if (skid_valid) begin
        out_res    <= skid_res;
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else if (in_fire) begin
        out_res   <= res_new;
        out_valid <= 1'b1;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (in_fire) begin
      // receiver stalled: park the new result
      skid_res   <= res_new;
      skid_valid <= 1'b1;
    end
  end

  `UTF8D_ASSERT_SAME(a_skid_behind_out, clk, rst, skid_valid, out_valid)
  `UTF8D_ASSERT_NEXT(a_skid_held, clk, rst, skid_valid && !out_item.ready, skid_valid)
  `UTF8D_ASSERT_SAME(a_empty_is_fffd, clk, rst,
    out_valid && (out_res.bytes_consumed == 3'd0),
    out_res.code_point == utf8d_pkg::CpReplacement)
  `UTF8D_ASSERT_SAME(a_scalar_range, clk, rst, out_valid,
    (out_res.code_point <= utf8d_pkg::CpMax) && (out_res.bytes_consumed <= 3'd4))

endmodule

// File: src/utf8d_lead.sv
module utf8d_lead (
  input  logic [7:0]            lead,
  output utf8d_pkg::lead_info_t info
);

  always_comb begin
    info.len = utf8d_pkg::SEQ_INVALID;
    info.lo  = utf8d_pkg::ContLo;
    info.hi  = utf8d_pkg::ContHi;
    if (lead < utf8d_pkg::AsciiEnd) begin
      info.len = utf8d_pkg::SEQ_ONE;
    end else if (lead < utf8d_pkg::LeadTwoMin) begin
      info.len = utf8d_pkg::SEQ_INVALID;
    end else if (lead < utf8d_pkg::LeadThreeMin) begin
      info.len = utf8d_pkg::SEQ_TWO;
    end else if (lead < utf8d_pkg::LeadFourMin) begin
      info.len = utf8d_pkg::SEQ_THREE;
      // overlong and surrogate guards
      if (lead == utf8d_pkg::LeadE0) info.lo = utf8d_pkg::LoAfterE0;
      if (lead == utf8d_pkg::LeadEd) info.hi = utf8d_pkg::HiAfterEd;
    end else if (lead < utf8d_pkg::LeadFourEnd) begin
      info.len = utf8d_pkg::SEQ_FOUR;
      // overlong and above-range guards
      if (lead == utf8d_pkg::LeadF0) info.lo = utf8d_pkg::LoAfterF0;
      if (lead == utf8d_pkg::LeadF4) info.hi = utf8d_pkg::HiAfterF4;
    end
  end

endmodule

// File: src/utf8d_lane.sv
module utf8d_lane (
  input  logic [7:0] data,
  input  logic [7:0] lo,
  input  logic [7:0] hi,
  output logic       ok,
  output logic [5:0] bits
);

  assign ok   = (data >= lo) && (data <= hi);
  assign bits = data[5:0];

endmodule

// File: src/utf8d_merge.sv
module utf8d_merge (
  input  utf8d_pkg::lead_info_t            info,
  input  logic [7:0]                       lead,
  input  logic [utf8d_pkg::NumLanes-1:0]   cont_ok,
  input  logic [utf8d_pkg::NumLanes*6-1:0] cont_bits,
  input  logic [2:0]                       avail,
  output utf8d_pkg::result_t               res
);

  logic [2:0] avail_sat;
  logic       seq_ok;

  always_comb begin
    avail_sat = (avail > utf8d_pkg::AvailMax) ? utf8d_pkg::AvailMax : avail;
    seq_ok = (avail_sat >= 3'(info.len)) && cont_ok[0]
             && ((info.len < utf8d_pkg::SEQ_THREE) || cont_ok[1])
             && ((info.len < utf8d_pkg::SEQ_FOUR) || cont_ok[2]);

    res.code_point     = utf8d_pkg::CpReplacement;
    res.bytes_consumed = 3'd1;
    if (avail_sat == 3'd0) begin
      res.bytes_consumed = 3'd0;
    end else begin
      unique case (info.len)
        utf8d_pkg::SEQ_ONE: begin
          res.code_point = {13'd0, lead};
        end
        utf8d_pkg::SEQ_TWO: begin
          if (seq_ok) begin
            res.code_point     = {10'd0, lead[4:0], cont_bits[5:0]};
            res.bytes_consumed = 3'(utf8d_pkg::SEQ_TWO);
          end
        end
        utf8d_pkg::SEQ_THREE: begin
          if (seq_ok) begin
            res.code_point     = {5'd0, lead[3:0], cont_bits[5:0], cont_bits[11:6]};
            res.bytes_consumed = 3'(utf8d_pkg::SEQ_THREE);
          end
        end
        utf8d_pkg::SEQ_FOUR: begin
          if (seq_ok) begin
            res.code_point     = {lead[2:0], cont_bits[5:0], cont_bits[11:6],
                                  cont_bits[17:12]};
            res.bytes_consumed = 3'(utf8d_pkg::SEQ_FOUR);
          end
        end
        default: begin
          res.code_point     = utf8d_pkg::CpReplacement;
          res.bytes_consumed = 3'd1;
        end
      endcase
    end
  end

endmodule

// File: tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RandomItems  = 1030;
  localparam int unsigned PhaseItems   = RandomItems / 3;
  localparam int unsigned CycleLimit   = 200000;
  localparam int unsigned HoldOffAt    = 800;
  localparam int unsigned HoldOffLen   = 60;
  localparam int unsigned NumDirected  = 25;
  localparam int unsigned MaxReported  = 10;

  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
    logic [2:0] avail;
  } window_t;

  typedef struct packed {
    window_t     win;
    logic        has_answer;
    logic [20:0] code_point;
    logic [2:0]  bytes_consumed;
  } dir_row_t;

  // rows with has_answer clear are left to the decoder model
  dir_row_t directed_rows [NumDirected] = '{
    '{'{8'h00, 8'h00, 8'h00, 8'h00, 3'd0}, 1'b1, 21'h00FFFD, 3'd0},  // empty window
    '{'{8'h00, 8'h00, 8'h00, 8'h00, 3'd1}, 1'b1, 21'h000000, 3'd1},
    '{'{8'h7F, 8'hFF, 8'hFF, 8'hFF, 3'd4}, 1'b1, 21'h00007F, 3'd1},
    '{'{8'h80, 8'h80, 8'h80, 8'h80, 3'd4}, 1'b1, 21'h00FFFD, 3'd1},  // stray continuation
    '{'{8'hC1, 8'hBF, 8'h00, 8'h00, 3'd2}, 1'b1, 21'h00FFFD, 3'd1},  // overlong lead
    '{'{8'hC2, 8'h80, 8'h00, 8'h00, 3'd2}, 1'b1, 21'h000080, 3'd2},
    '{'{8'hDF, 8'hBF, 8'hFF, 8'hFF, 3'd7}, 1'b1, 21'h0007FF, 3'd2},  // count saturates
    '{'{8'hC2, 8'h80, 8'h00, 8'h00, 3'd1}, 1'b1, 21'h00FFFD, 3'd1},  // truncated
    '{'{8'hC3, 8'h7F, 8'h00, 8'h00, 3'd2}, 1'b1, 21'h00FFFD, 3'd1},  // bad continuation
    '{'{8'hE0, 8'h9F, 8'hBF, 8'h00, 3'd3}, 1'b1, 21'h00FFFD, 3'd1},  // overlong three
    '{'{8'hE0, 8'hA0, 8'h80, 8'h00, 3'd3}, 1'b1, 21'h000800, 3'd3},
    '{'{8'hED, 8'hA0, 8'h80, 8'h00, 3'd3}, 1'b1, 21'h00FFFD, 3'd1},  // surrogate
    '{'{8'hED, 8'h9F, 8'hBF, 8'h00, 3'd3}, 1'b1, 21'h00D7FF, 3'd3},
    '{'{8'hE1, 8'h80, 8'hC0, 8'h00, 3'd3}, 1'b1, 21'h00FFFD, 3'd1},  // bad third byte
    '{'{8'hE2, 8'h82, 8'hAC, 8'h00, 3'd2}, 1'b1, 21'h00FFFD, 3'd1},
    '{'{8'hE2, 8'h82, 8'hAC, 8'h55, 3'd5}, 1'b0, 21'h000000, 3'd0},
    '{'{8'hF0, 8'h8F, 8'hBF, 8'hBF, 3'd4}, 1'b1, 21'h00FFFD, 3'd1},  // overlong four
    '{'{8'hF0, 8'h90, 8'h80, 8'h80, 3'd4}, 1'b1, 21'h010000, 3'd4},
    '{'{8'hF4, 8'h8F, 8'hBF, 8'hBF, 3'd6}, 1'b1, 21'h10FFFF, 3'd4},
    '{'{8'hF4, 8'h90, 8'h80, 8'h80, 3'd4}, 1'b1, 21'h00FFFD, 3'd1},  // above 10ffff
    '{'{8'hF5, 8'h80, 8'h80, 8'h80, 3'd4}, 1'b1, 21'h00FFFD, 3'd1},
    '{'{8'hFF, 8'hFF, 8'hFF, 8'hFF, 3'd7}, 1'b1, 21'h00FFFD, 3'd1},
    '{'{8'hF0, 8'h9F, 8'h98, 8'h80, 3'd3}, 1'b1, 21'h00FFFD, 3'd1},
    '{'{8'hF1, 8'h80, 8'h80, 8'h7F, 3'd4}, 1'b1, 21'h00FFFD, 3'd1},  // bad fourth byte
    '{'{8'hF3, 8'hAB, 8'h9C, 8'h8D, 3'd4}, 1'b0, 21'h000000, 3'd0}
  };

  logic clk;
  logic rst;

  utf8d_in_if  in_ch ();
  utf8d_out_if out_ch ();

  utf8_code_point_decoder_unit u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_item  (in_ch),
    .out_item (out_ch)
  );

  utf8d_pkg::result_t pending_results [$];
  int unsigned        mismatches;
  int unsigned        results_seen;
  int unsigned        send_gap_pct;
  int unsigned        recv_gap_pct;

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit is_cont(logic [7:0] b);
    return b >= utf8d_pkg::ContLo && b <= utf8d_pkg::ContHi;
  endfunction

  function automatic utf8d_pkg::result_t decode_window(window_t w);
    utf8d_pkg::result_t  r;
    logic [2:0]          avail;
    utf8d_pkg::seq_len_e len;
    logic [7:0]          lo;
    logic [7:0]          hi;
    r.code_point     = utf8d_pkg::CpReplacement;
    r.bytes_consumed = 3'd1;
    avail = (w.avail > utf8d_pkg::AvailMax) ? utf8d_pkg::AvailMax : w.avail;
    lo = utf8d_pkg::ContLo;
    hi = utf8d_pkg::ContHi;
    if (w.b0 < utf8d_pkg::AsciiEnd) begin
      len = utf8d_pkg::SEQ_ONE;
    end else if (w.b0 < utf8d_pkg::LeadTwoMin) begin
      len = utf8d_pkg::SEQ_INVALID;
    end else if (w.b0 < utf8d_pkg::LeadThreeMin) begin
      len = utf8d_pkg::SEQ_TWO;
    end else if (w.b0 < utf8d_pkg::LeadFourMin) begin
      len = utf8d_pkg::SEQ_THREE;
      if (w.b0 == utf8d_pkg::LeadE0) lo = utf8d_pkg::LoAfterE0;
      if (w.b0 == utf8d_pkg::LeadEd) hi = utf8d_pkg::HiAfterEd;
    end else if (w.b0 < utf8d_pkg::LeadFourEnd) begin
      len = utf8d_pkg::SEQ_FOUR;
      if (w.b0 == utf8d_pkg::LeadF0) lo = utf8d_pkg::LoAfterF0;
      if (w.b0 == utf8d_pkg::LeadF4) hi = utf8d_pkg::HiAfterF4;
    end else begin
      len = utf8d_pkg::SEQ_INVALID;
    end

    if (avail == 3'd0) begin
      r.bytes_consumed = 3'd0;
    end else if (len == utf8d_pkg::SEQ_ONE) begin
      r.code_point = {13'd0, w.b0};
    end else if (len != utf8d_pkg::SEQ_INVALID && avail >= 3'(len) &&
                 w.b1 >= lo && w.b1 <= hi) begin
      case (len)
        utf8d_pkg::SEQ_TWO: begin
          r.code_point     = {10'd0, w.b0[4:0], w.b1[5:0]};
          r.bytes_consumed = 3'd2;
        end
        utf8d_pkg::SEQ_THREE: begin
          if (is_cont(w.b2)) begin
            r.code_point     = {5'd0, w.b0[3:0], w.b1[5:0], w.b2[5:0]};
            r.bytes_consumed = 3'd3;
          end
        end
        utf8d_pkg::SEQ_FOUR: begin
          if (is_cont(w.b2) && is_cont(w.b3)) begin
            r.code_point     = {w.b0[2:0], w.b1[5:0], w.b2[5:0], w.b3[5:0]};
            r.bytes_consumed = 3'd4;
          end
        end
        default: ;
      endcase
    end
    return r;
  endfunction

  // mostly well-formed sequences, mixed with truncated, corrupted and pure noise
  function automatic window_t random_window();
    window_t     w;
    int unsigned n;
    int unsigned kind;
    int unsigned pos;
    logic [20:0] cp;
    logic [20:0] lo;
    logic [20:0] hi;
    w    = 35'({$urandom(), 8'($urandom())});
    kind = $urandom_range(99);
    if (kind >= 90) return w;
    n = $urandom_range(4, 1);
    case (n)
      1: begin lo = 21'h000000; hi = 21'h00007F; end
      2: begin lo = 21'h000080; hi = 21'h0007FF; end
      3: begin lo = 21'h000800; hi = 21'h00FFFF; end
      default: begin lo = 21'h010000; hi = utf8d_pkg::CpMax; end
    endcase
    if ($urandom_range(7) == 0) begin
      cp = $urandom_range(1) ? lo : hi;
    end else begin
      cp = 21'($urandom_range(hi, lo));
    end
    // keep clear of the surrogate block
    if (cp >= 21'h00D800 && cp <= 21'h00DFFF) cp = cp ^ 21'h001000;
    case (n)
      1: w.b0 = cp[7:0];
      2: begin
        w.b0 = {3'b110, cp[10:6]};
        w.b1 = {2'b10, cp[5:0]};
      end
      3: begin
        w.b0 = {4'b1110, cp[15:12]};
        w.b1 = {2'b10, cp[11:6]};
        w.b2 = {2'b10, cp[5:0]};
      end
      default: begin
        w.b0 = {5'b11110, cp[20:18]};
        w.b1 = {2'b10, cp[17:12]};
        w.b2 = {2'b10, cp[11:6]};
        w.b3 = {2'b10, cp[5:0]};
      end
    endcase
    if (kind < 80 && $urandom_range(9) == 0) begin
      w.avail = 3'($urandom_range(7, 5));
    end else begin
      w.avail = 3'($urandom_range(4, n));
    end
    if (kind >= 70 && kind < 80) begin
      w.avail = 3'($urandom_range(n - 1, 0));
    end else if (kind >= 80) begin
      pos = $urandom_range(n - 1, 0);
      case (pos)
        0: w.b0 = 8'($urandom());
        1: w.b1 = 8'($urandom());
        2: w.b2 = 8'($urandom());
        default: w.b3 = 8'($urandom());
      endcase
    end
    return w;
  endfunction

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_window(window_t w, utf8d_pkg::result_t answer);
    while ($urandom_range(99) < send_gap_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid           <= 1'b1;
    in_ch.byte_first      <= w.b0;
    in_ch.byte_second     <= w.b1;
    in_ch.byte_third      <= w.b2;
    in_ch.byte_fourth     <= w.b3;
    in_ch.bytes_available <= w.avail;
    do @(posedge clk); while (!in_ch.ready);
    pending_results.push_back(answer);
    @(negedge clk);
  endtask

  // receiver: random back-pressure plus one long hold-off to fill the block
  initial begin
    int unsigned stall_left;
    bit          hold_done;
    stall_left   = 0;
    hold_done    = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (!hold_done && results_seen >= HoldOffAt) begin
        hold_done  = 1'b1;
        stall_left = HoldOffLen;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_gap_pct);
      end
    end
  end

  always @(posedge clk) begin
    utf8d_pkg::result_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        if (mismatches < MaxReported) begin
          $display("unexpected result: code_point %h bytes_consumed %0d",
                   out_ch.code_point, out_ch.bytes_consumed);
        end
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (out_ch.code_point !== want.code_point ||
            out_ch.bytes_consumed !== want.bytes_consumed) begin
          if (mismatches < MaxReported) begin
            $display("mismatch: code_point %h want %h, bytes_consumed %0d want %0d",
                     out_ch.code_point, want.code_point,
                     out_ch.bytes_consumed, want.bytes_consumed);
          end
          mismatches++;
        end
      end
    end
  end

  initial begin
    repeat (CycleLimit) @(posedge clk);
    $display("utf8_code_point_decoder_unit test failed");
    $finish;
  end

  initial begin
    window_t            w;
    utf8d_pkg::result_t answer;
    mismatches            = 0;
    results_seen          = 0;
    send_gap_pct          = 10;
    recv_gap_pct          = 56;
    rst                   = 1'b1;
    in_ch.valid           = 1'b0;
    in_ch.byte_first      = 8'h00;
    in_ch.byte_second     = 8'h00;
    in_ch.byte_third      = 8'h00;
    in_ch.byte_fourth     = 8'h00;
    in_ch.bytes_available = 3'd0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      w = directed_rows[i].win;
      if (directed_rows[i].has_answer) begin
        answer.code_point     = directed_rows[i].code_point;
        answer.bytes_consumed = directed_rows[i].bytes_consumed;
      end else begin
        answer = decode_window(w);
      end
      send_window(w, answer);
    end

    for (int unsigned i = 0; i < RandomItems; i++) begin
      if (i == PhaseItems) begin
        // let the block drain completely before swapping the idle pattern
        in_ch.valid <= 1'b0;
        wait (pending_results.size() == 0);
        @(negedge clk);
        send_gap_pct = 56;
        recv_gap_pct = 10;
      end else if (i == 2 * PhaseItems) begin
        send_gap_pct = 0;
        recv_gap_pct = 0;
      end
      w = random_window();
      send_window(w, decode_window(w));
    end

    in_ch.valid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (4) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("utf8_code_point_decoder_unit test passed");
    end else begin
      $display("utf8_code_point_decoder_unit test failed");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+src
src/utf8d_pkg.sv
src/utf8d_if.sv
src/utf8d_lead.sv
src/utf8d_lane.sv
src/utf8d_merge.sv
src/utf8_code_point_decoder_unit.sv
tb/tb.sv
